[hdl/tmf_pkg.sv]
package tmf_pkg;

  // Field widths
  localparam int SampleW  = 12;
  localparam int ChanW    = 2;
  localparam int SumW     = 16;
  localparam int TrimW    = 15;
  localparam int VrefW    = 13;
  localparam int CountW   = 4;
  localparam int MvW      = 13;

  // Window and scaling constants
  localparam int WindowLen      = 10;
  localparam int ScaleShift     = 15;
  localparam int VrefReset      = 3300;
  localparam int NumChannelsDef = 4;
  localparam int NumChannelsMax = 16;

  // Trimmed window result passed from the window stage to the scaling stage
  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [TrimW-1:0] trimmed;
  } trim_t;

endpackage

[hdl/tmf_if.sv]
// Sample channel: one ADC sample tagged with its channel
interface tmf_in_if;
  logic                         valid;
  logic                         ready;
  logic [tmf_pkg::SampleW-1:0]  sample;
  logic [tmf_pkg::ChanW-1:0]    channel;

  modport source (output valid, sample, channel, input ready);
  modport sink   (input valid, sample, channel, output ready);
endinterface

// Result channel: one completed window
interface tmf_out_if;
  logic                        valid;
  logic                        ready;
  logic [tmf_pkg::ChanW-1:0]   out_channel;
  logic [tmf_pkg::TrimW-1:0]   trimmed_avg_x8;
  logic [tmf_pkg::MvW-1:0]     millivolts;

  modport source (output valid, out_channel, trimmed_avg_x8, millivolts, input ready);
  modport sink   (input valid, out_channel, trimmed_avg_x8, millivolts, output ready);
endinterface

[hdl/multichannel_trimmed_mean_filter.sv]
// Multichannel trimmed-mean filter over windows of ten ADC samples.
// smp carries one 12-bit sample and its 2-bit channel per transfer; samples
// for channels at or above NumChannels are dropped. Every tenth sample of a
// channel closes its window: res then carries the channel, sum minus max
// minus min (eight times the mean, 12.3 fixed point) and millivolts =
// trimmed * vref >> 15. The window then restarts empty.
// vref_we_i/vref_wdata_i write the reference voltage; write only when idle.
// Throughput: one sample per cycle, back to back, on any mix of channels,
// while smp.ready is high. A closing sample's result reaches res through
// the input register, taking it at the transfer, the window update stage,
// registering the trimmed sum, and the multiply into the output register.
// The output register decouples the receiver: a stall holds the result,
// and samples keep flowing until the stages in front of it are full, then
// smp.ready drops.
// Reset clears all windows, empties the pipeline and sets vref to 3300 mV;
// no clearing pass is needed, samples are accepted right after reset.
module multichannel_trimmed_mean_filter #(
  parameter int NumChannels = tmf_pkg::NumChannelsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vref_we_i,
  input  logic [tmf_pkg::VrefW-1:0]  vref_wdata_i,
  tmf_in_if.sink                     smp,
  tmf_out_if.source                  res
);
  import tmf_pkg::*;

  trim_t trim;
  logic  trim_valid;
  logic  trim_ready;

  // Window accumulation
  tmf_window #(
    .NumChannels (NumChannels)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp          (smp),
    .trim_o       (trim),
    .trim_valid_o (trim_valid),
    .trim_ready_i (trim_ready)
  );

  // Millivolt scaling and output register
  tmf_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vref_we_i    (vref_we_i),
    .vref_wdata_i (vref_wdata_i),
    .trim_i       (trim),
    .trim_valid_i (trim_valid),
    .trim_ready_o (trim_ready),
    .res          (res)
  );

endmodule

[hdl/tmf_window.sv]
module tmf_window #(
  parameter int NumChannels = tmf_pkg::NumChannelsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tmf_in_if.sink          smp,
  output tmf_pkg::trim_t  trim_o,
  output logic            trim_valid_o,
  input  logic            trim_ready_i
);
  import tmf_pkg::*;

  localparam int ChIdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int CmpW   = ChanW + $clog2(NumChannelsMax + 1);

  // Input register
  logic               in_vld_q;
  logic [SampleW-1:0] in_sample_q;
  logic [ChanW-1:0]   in_chan_q;

  // Per-channel window state
  logic [SumW-1:0]    sum_q   [NumChannels];
  logic [SampleW-1:0] max_q   [NumChannels];
  logic [SampleW-1:0] min_q   [NumChannels];
  logic [CountW-1:0]  count_q [NumChannels];

  // Result register toward the scaling stage
  logic   trim_vld_q;
  trim_t  trim_q;

  logic                     mid_free;
  logic                     in_fire;
  logic                     ch_ok;
  logic [ChanW+ChIdxW-1:0]  ch_ext;
  logic [ChIdxW-1:0]        idx;
  logic                     first;
  logic [SampleW-1:0]       new_max;
  logic [SampleW-1:0]       new_min;
  logic [SumW-1:0]          new_sum;
  logic [CountW-1:0]        new_count;
  logic                     done;
  logic [SumW-1:0]          trim_full;

  // Handshake between stages
  assign mid_free  = !trim_vld_q || trim_ready_i;
  assign in_fire   = in_vld_q && mid_free;
  assign smp.ready = !in_vld_q || mid_free;

  // Channel decode; out-of-range channels are dropped
  assign ch_ok  = (CmpW'(in_chan_q) < CmpW'(NumChannels));
  assign ch_ext = (ChanW + ChIdxW)'(in_chan_q);
  assign idx    = ch_ext[ChIdxW-1:0];

  // Window update and trimmed sum
  always_comb begin
    first     = (count_q[idx] == '0);
    new_max   = (first || in_sample_q > max_q[idx]) ? in_sample_q : max_q[idx];
    new_min   = (first || in_sample_q < min_q[idx]) ? in_sample_q : min_q[idx];
    new_sum   = sum_q[idx] + SumW'(in_sample_q);
    new_count = count_q[idx] + CountW'(1);
    done      = (new_count >= CountW'(WindowLen));
    trim_full = new_sum - SumW'(new_max) - SumW'(new_min);
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (smp.ready) begin
      in_vld_q <= smp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp.valid && smp.ready) begin
      in_sample_q <= smp.sample;
      in_chan_q   <= smp.channel;
    end
  end

  // Window state: accumulate, clear after the tenth sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        sum_q[i]   <= '0;
        max_q[i]   <= '0;
        min_q[i]   <= '0;
        count_q[i] <= '0;
      end
    end else if (in_fire && ch_ok) begin
      if (done) begin
        sum_q[idx]   <= '0;
        max_q[idx]   <= '0;
        min_q[idx]   <= '0;
        count_q[idx] <= '0;
      end else begin
        sum_q[idx]   <= new_sum;
        max_q[idx]   <= new_max;
        min_q[idx]   <= new_min;
        count_q[idx] <= new_count;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_vld_q <= 1'b0;
    end else if (mid_free) begin
      trim_vld_q <= in_fire && ch_ok && done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && ch_ok && done) begin
      trim_q.channel <= in_chan_q;
      trim_q.trimmed <= trim_full[TrimW-1:0];
    end
  end

  assign trim_o       = trim_q;
  assign trim_valid_o = trim_vld_q;

endmodule

[hdl/tmf_scale.sv]
module tmf_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vref_we_i,
  input  logic [tmf_pkg::VrefW-1:0]  vref_wdata_i,
  input  tmf_pkg::trim_t             trim_i,
  input  logic                       trim_valid_i,
  output logic                       trim_ready_o,
  tmf_out_if.source                  res
);
  import tmf_pkg::*;

  localparam int ProdW = TrimW + VrefW;

  logic [VrefW-1:0]  vref_q;
  logic              out_vld_q;
  logic [ChanW-1:0]  out_chan_q;
  logic [TrimW-1:0]  out_trim_q;
  logic [MvW-1:0]    out_mv_q;
  logic [ProdW-1:0]  product;
  logic              take;

  assign trim_ready_o = !out_vld_q || res.ready;
  assign take         = trim_valid_i && trim_ready_o;

  // Scale to millivolts, truncating
  assign product = ProdW'(trim_i.trimmed) * ProdW'(vref_q);

  // Reference voltage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q <= VrefW'(VrefReset);
    end else if (vref_we_i) begin
      vref_q <= vref_wdata_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (trim_ready_o) begin
      out_vld_q <= trim_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_chan_q <= trim_i.channel;
      out_trim_q <= trim_i.trimmed;
      out_mv_q   <= product[ScaleShift +: MvW];
    end
  end

  assign res.valid          = out_vld_q;
  assign res.out_channel    = out_chan_q;
  assign res.trimmed_avg_x8 = out_trim_q;
  assign res.millivolts     = out_mv_q;

endmodule

[tb/sv/tmf_checker.sv]
module tmf_checker
  import tmf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vref_we_i,
  input  logic [VrefW-1:0]  vref_wdata_i,
  tmf_in_if                 smp,
  tmf_out_if                res,
  output int                fail_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumCh     = NumChannelsDef;
  localparam int MaxReport = 10;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [TrimW-1:0] trimmed;
    logic [MvW-1:0]   mv;
  } window_result_t;

  // Per-channel window accumulators, mirrored from the block's behavior
  logic [SumW-1:0]    win_sum [NumCh];
  logic [SampleW-1:0] win_max [NumCh];
  logic [SampleW-1:0] win_min [NumCh];
  logic [CountW-1:0]  win_cnt [NumCh];
  logic [VrefW-1:0]   vref_mv;

  window_result_t expected_windows[$];

  // Fold one sample into its channel window; queue the result on the tenth
  function automatic void accumulate_sample(logic [SampleW-1:0] s, logic [ChanW-1:0] c);
    window_result_t               r;
    logic [SumW-1:0]              diff;
    logic [TrimW+VrefW-1:0]       prod;
    if (int'(c) >= NumCh) return;
    if (win_cnt[c] == '0) begin
      win_max[c] = s;
      win_min[c] = s;
    end else begin
      if (s > win_max[c]) win_max[c] = s;
      if (s < win_min[c]) win_min[c] = s;
    end
    win_sum[c] = win_sum[c] + SumW'(s);
    win_cnt[c] = win_cnt[c] + CountW'(1);
    if (win_cnt[c] != CountW'(WindowLen)) return;
    diff      = win_sum[c] - SumW'(win_max[c]) - SumW'(win_min[c]);
    r.chan    = c;
    r.trimmed = diff[TrimW-1:0];
    prod      = (TrimW+VrefW)'(r.trimmed) * (TrimW+VrefW)'(vref_mv);
    r.mv      = MvW'(prod >> ScaleShift);
    expected_windows.push_back(r);
    win_sum[c] = '0;
    win_max[c] = '0;
    win_min[c] = '0;
    win_cnt[c] = '0;
  endfunction

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t exp_r;
    if (!rst_ni) begin
      vref_mv = VrefW'(VrefReset);
      for (int c = 0; c < NumCh; c++) begin
        win_sum[c] = '0;
        win_max[c] = '0;
        win_min[c] = '0;
        win_cnt[c] = '0;
      end
      expected_windows.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (vref_we_i) vref_mv = vref_wdata_i;
      if (smp.valid && smp.ready) accumulate_sample(smp.sample, smp.channel);
      if (res.valid && res.ready) begin
        if (expected_windows.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReport)
            $display("[%0t] unexpected result: ch %0d trimmed %0d mv %0d", $realtime,
                     res.out_channel, res.trimmed_avg_x8, res.millivolts);
        end else begin
          exp_r = expected_windows.pop_front();
          if (res.out_channel !== exp_r.chan || res.trimmed_avg_x8 !== exp_r.trimmed ||
              res.millivolts !== exp_r.mv) begin
            fail_count_o++;
            if (fail_count_o <= MaxReport)
              $display({"[%0t] result mismatch: exp ch %0d trimmed %0d mv %0d, ",
                        "got ch %0d trimmed %0d mv %0d"},
                       $realtime, exp_r.chan, exp_r.trimmed, exp_r.mv,
                       res.out_channel, res.trimmed_avg_x8, res.millivolts);
          end
        end
      end
      pending_o = expected_windows.size();
    end
  end

  // Anything still queued at the end is reported by the top via pending_o
endmodule

[tb/sv/tb.sv]
module tb;
  import tmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit     = 4000;
  localparam int NumPhases     = 6;
  localparam int PhaseItems    = 80;
  localparam int HoldPhase     = 2;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 8;
  localparam logic [SampleW-1:0] SampleMax = '1;

  logic             clk_i;
  logic             rst_ni;
  logic             vref_we;
  logic [VrefW-1:0] vref_wdata;
  int               fail_count;
  int unsigned      pending;
  bit               hold_req;
  bit               hold_done;
  int               stall_cycles;

  tmf_in_if  smp_if ();
  tmf_out_if res_if ();

  multichannel_trimmed_mean_filter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vref_we_i    (vref_we),
    .vref_wdata_i (vref_wdata),
    .smp          (smp_if),
    .res          (res_if)
  );

  tmf_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vref_we_i    (vref_we),
    .vref_wdata_i (vref_wdata),
    .smp          (smp_if),
    .res          (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Bias toward the sample extremes
  function automatic logic [SampleW-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return SampleMax;
    return SampleW'($urandom_range(0, 4095));
  endfunction

  // One sample transfer, then an optional idle gap
  task automatic send_sample(logic [SampleW-1:0] s, logic [ChanW-1:0] c, bit gaps);
    int gap;
    smp_if.valid   <= 1'b1;
    smp_if.sample  <= s;
    smp_if.channel <= c;
    do @(posedge clk_i); while (!smp_if.ready);
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait for all windows to drain, then let the pipeline settle
  task automatic wait_idle();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_vref(logic [VrefW-1:0] v);
    vref_we    <= 1'b1;
    vref_wdata <= v;
    @(posedge clk_i);
    vref_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result receiver: random ready with one long hold on request
  initial begin : receiver
    hold_done    = 1'b0;
    res_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < 65) begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int               sent;
    int               style;
    bit               gaps;
    logic [ChanW-1:0] c;
    logic [SampleW-1:0] s;
    logic [VrefW-1:0] vref_val;

    hold_req       = 1'b0;
    rst_ni         = 1'b0;
    vref_we        = 1'b0;
    vref_wdata     = '0;
    smp_if.valid   = 1'b0;
    smp_if.sample  = '0;
    smp_if.channel = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full-scale and zero windows on two channels, then mixed extremes
    for (int k = 0; k < WindowLen; k++) begin
      send_sample(SampleMax, 2'd0, 1'b0);
      send_sample('0, 2'd1, 1'b0);
    end
    send_sample(SampleMax, 2'd2, 1'b1);
    send_sample('0, 2'd2, 1'b1);
    send_sample(12'd2048, 2'd2, 1'b1);
    send_sample(12'd1, 2'd2, 1'b1);
    send_sample(12'd4094, 2'd3, 1'b1);
    wait_idle();

    // Random phases, each under its own reference voltage
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       vref_val = '0;
        1:       vref_val = '1;
        2:       vref_val = VrefW'(1);
        3:       vref_val = VrefW'(5000);
        4:       vref_val = VrefW'($urandom_range(1, 5000));
        default: vref_val = VrefW'($urandom_range(0, 8191));
      endcase
      write_vref(vref_val);
      gaps = (p != HoldPhase) && (p != 4);
      if (p == HoldPhase) hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          // Burst on one channel: spans at least one whole window
          c     = ChanW'($urandom_range(0, 3));
          style = $urandom_range(0, 2);
          for (int k = 0; k < 2 * WindowLen; k++) begin
            case (style)
              0:       s = SampleMax;
              1:       s = '0;
              default: s = pick_sample();
            endcase
            send_sample(s, c, gaps);
            sent++;
          end
        end else begin
          send_sample(pick_sample(), ChanW'($urandom_range(0, 3)), gaps);
          sent++;
        end
      end
      // Sender pauses until every result is back
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[multichannel_trimmed_mean_filter.f]
hdl/tmf_pkg.sv
hdl/tmf_if.sv
hdl/tmf_window.sv
hdl/tmf_scale.sv
hdl/multichannel_trimmed_mean_filter.sv
tb/sv/tmf_checker.sv
tb/sv/tb.sv
